>>> rtl/button_debounce_gesture_detector_unit_macros.svh
// Assertion macros for the button debounce and gesture detector.
// Every macro expects the signals clock and reset to exist in the scope where it is used.
`ifndef BUTTON_DEBOUNCE_GESTURE_DETECTOR_UNIT_MACROS_SVH
`define BUTTON_DEBOUNCE_GESTURE_DETECTOR_UNIT_MACROS_SVH

// The property must hold in the same cycle.
`define BDGD_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed in %m");

// The property must hold in the cycle after the antecedent.
`define BDGD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed in %m");

`endif

>>> rtl/bdgd_pkg.sv
// Shared types, constants and gesture tables for the button debounce and gesture detector.
// It has no dependencies.
package bdgd_pkg;

   localparam int CountWidth = 16;
   localparam int TicksWidth = 16;
   localparam int EventWidth = 4;
   localparam int CsrIndexWidth = 2;

   localparam logic [TicksWidth-1:0] DebounceTicksReset = TicksWidth'(50);
   localparam logic [TicksWidth-1:0] RepeatTicksReset = TicksWidth'(200);

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_DEBOUNCE_TICKS = 2'd0,
      CSR_REPEAT_TICKS   = 2'd1
   } csr_index_type;

   typedef enum logic [EventWidth-1:0] {
      EV_NONE      = 4'd0,
      EV_DOWN      = 4'd1,
      EV_UP        = 4'd2,
      EV_CLICK     = 4'd3,
      EV_DOUBLE    = 4'd4,
      EV_TRIPLE    = 4'd5,
      EV_QUADRUPLE = 4'd6,
      EV_QUINTUPLE = 4'd7,
      EV_HOLD      = 4'd8
   } event_code_type;

   typedef enum logic [3:0] {
      GS_START   = 4'd0,
      GS_DOWN1   = 4'd1,
      GS_CLICK1  = 4'd2,
      GS_DOWN2   = 4'd3,
      GS_CLICK2  = 4'd4,
      GS_DOWN3   = 4'd5,
      GS_CLICK3  = 4'd6,
      GS_DOWN4   = 4'd7,
      GS_CLICK4  = 4'd8,
      GS_DOWN5   = 4'd9,
      GS_CLICK5  = 4'd10,
      GS_HOLD    = 4'd11,
      GS_INVALID = 4'd12
   } gesture_state_type;

   typedef enum logic [1:0] {
      FEED_DOWN = 2'd0,
      FEED_UP   = 2'd1,
      FEED_TICK = 2'd2
   } feed_kind_type;

   function automatic gesture_state_type next_gesture(gesture_state_type cur,
                                                      feed_kind_type kind);
      gesture_state_type on_down;
      gesture_state_type on_up;
      gesture_state_type on_tick;
      on_down = GS_INVALID;
      on_up   = GS_START;
      on_tick = GS_INVALID;
      case (cur)
         GS_START: begin
            on_down = GS_DOWN1;  on_up = GS_START;  on_tick = GS_START;
         end
         GS_DOWN1: begin
            on_down = GS_DOWN1;  on_up = GS_CLICK1; on_tick = GS_HOLD;
         end
         GS_CLICK1: begin
            on_down = GS_DOWN2;  on_up = GS_CLICK1; on_tick = GS_START;
         end
         GS_DOWN2: begin
            on_down = GS_DOWN2;  on_up = GS_CLICK2; on_tick = GS_INVALID;
         end
         GS_CLICK2: begin
            on_down = GS_DOWN3;  on_up = GS_CLICK2; on_tick = GS_START;
         end
         GS_DOWN3: begin
            on_down = GS_DOWN3;  on_up = GS_CLICK3; on_tick = GS_INVALID;
         end
         GS_CLICK3: begin
            on_down = GS_DOWN4;  on_up = GS_CLICK3; on_tick = GS_START;
         end
         GS_DOWN4: begin
            on_down = GS_DOWN4;  on_up = GS_CLICK4; on_tick = GS_INVALID;
         end
         GS_CLICK4: begin
            on_down = GS_DOWN5;  on_up = GS_CLICK4; on_tick = GS_START;
         end
         GS_DOWN5: begin
            on_down = GS_DOWN5;  on_up = GS_CLICK5; on_tick = GS_INVALID;
         end
         GS_CLICK5: begin
            on_down = GS_INVALID; on_up = GS_CLICK5; on_tick = GS_START;
         end
         GS_HOLD: begin
            on_down = GS_HOLD;   on_up = GS_START;  on_tick = GS_HOLD;
         end
         default: begin
            // invalid state and unused codes
            on_down = GS_INVALID; on_up = GS_START; on_tick = GS_INVALID;
         end
      endcase
      case (kind)
         FEED_DOWN: next_gesture = on_down;
         FEED_UP:   next_gesture = on_up;
         default:   next_gesture = on_tick;
      endcase
   endfunction

   function automatic event_code_type tick_event(gesture_state_type cur);
      case (cur)
         GS_DOWN1:  tick_event = EV_HOLD;
         GS_CLICK1: tick_event = EV_CLICK;
         GS_CLICK2: tick_event = EV_DOUBLE;
         GS_CLICK3: tick_event = EV_TRIPLE;
         GS_CLICK4: tick_event = EV_QUADRUPLE;
         GS_CLICK5: tick_event = EV_QUINTUPLE;
         GS_HOLD:   tick_event = EV_HOLD;
         default:   tick_event = EV_NONE;
      endcase
   endfunction

   function automatic logic [CountWidth-1:0] sat_inc(logic [CountWidth-1:0] v);
      sat_inc = (v == {CountWidth{1'b1}}) ? v : v + CountWidth'(1);
   endfunction

endpackage

>>> rtl/button_debounce_gesture_detector_unit.sv
// Button debounce and gesture detector: debounces one pin sample per item and runs the
// click / multi-click / hold gesture machine. Depends on bdgd_pkg and the macros header.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_ready  | req_pin_level
//   rsp     | out       | rsp_valid / rsp_ready  | rsp_event_code, rsp_hold_count
//   csr     | in        | csr_write_en           | csr_index, csr_wdata
//
// One item per cycle while req_ready is high. Each accepted sample updates the debounce
// and gesture state in the cycle it is taken; its result sits in the output register in
// the cycle after. There is a single output register.
// req_ready is high whenever the output register is empty or is being drained this cycle.
// Synchronous reset sets all control state (last level high); registers come back as 50 and 200.
`include "button_debounce_gesture_detector_unit_macros.svh"

module button_debounce_gesture_detector_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_pin_level,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [bdgd_pkg::EventWidth-1:0]       rsp_event_code,
   output logic [bdgd_pkg::CountWidth-1:0]       rsp_hold_count,
   input  logic                                  csr_write_en,
   input  logic [bdgd_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [bdgd_pkg::TicksWidth-1:0]       csr_wdata
);
   import bdgd_pkg::*;

   logic [TicksWidth-1:0] debounce_ticks_ff;
   logic [TicksWidth-1:0] repeat_ticks_ff;

   logic                  last_level_ff,       last_level_in;
   logic                  debounce_pending_ff, debounce_pending_in;
   logic [CountWidth-1:0] debounce_elapsed_ff, debounce_elapsed_in;
   logic [CountWidth-1:0] repeat_elapsed_ff,   repeat_elapsed_in;
   gesture_state_type     gesture_ff,          gesture_in;
   logic [CountWidth-1:0] hold_ticks_ff,       hold_ticks_in;

   logic                  rsp_valid_ff,        rsp_valid_in;
   event_code_type        rsp_event_ff,        rsp_event_in;
   logic [CountWidth-1:0] rsp_hold_ff,         rsp_hold_in;

   logic                  accept;
   logic [TicksWidth-1:0] repeat_limit;
   logic                  feed;
   feed_kind_type         feed_kind;
   gesture_state_type     gesture_next;

   assign req_ready      = !rsp_valid_ff || rsp_ready;
   assign accept         = req_valid && req_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_code = rsp_event_ff;
   assign rsp_hold_count = rsp_hold_ff;

   // a zero repeat interval behaves as one
   assign repeat_limit = (repeat_ticks_ff == '0) ? TicksWidth'(1) : repeat_ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ticks_ff <= DebounceTicksReset;
         repeat_ticks_ff   <= RepeatTicksReset;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_DEBOUNCE_TICKS: debounce_ticks_ff <= csr_wdata;
            CSR_REPEAT_TICKS:   repeat_ticks_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      last_level_in       = last_level_ff;
      debounce_pending_in = debounce_pending_ff;
      debounce_elapsed_in = debounce_elapsed_ff;
      repeat_elapsed_in   = repeat_elapsed_ff;
      gesture_in          = gesture_ff;
      hold_ticks_in       = hold_ticks_ff;
      rsp_event_in        = EV_NONE;
      feed                = 1'b0;
      feed_kind           = FEED_TICK;
      gesture_next        = gesture_ff;

      if (accept) begin
         repeat_elapsed_in = sat_inc(repeat_elapsed_ff);
         if (req_pin_level != last_level_ff) begin
            last_level_in       = req_pin_level;
            debounce_pending_in = 1'b1;
            debounce_elapsed_in = '0;
         end else begin
            if (debounce_pending_ff) begin
               debounce_elapsed_in = sat_inc(debounce_elapsed_ff);
               if (debounce_elapsed_in >= CountWidth'(debounce_ticks_ff)) begin
                  debounce_pending_in = 1'b0;
                  repeat_elapsed_in   = '0;
                  feed                = 1'b1;
                  feed_kind           = req_pin_level ? FEED_UP : FEED_DOWN;
                  rsp_event_in        = req_pin_level ? EV_UP : EV_DOWN;
               end
            end
            // cleared counter above rules out a tick on the same item
            if (repeat_elapsed_in >= CountWidth'(repeat_limit)) begin
               repeat_elapsed_in = '0;
               feed              = 1'b1;
               feed_kind         = FEED_TICK;
               rsp_event_in      = tick_event(gesture_ff);
            end
         end
         if (feed) begin
            gesture_next = next_gesture(gesture_ff, feed_kind);
            gesture_in   = gesture_next;
            if (gesture_next == GS_HOLD) begin
               hold_ticks_in = (gesture_ff != GS_HOLD) ? CountWidth'(1)
                                                       : sat_inc(hold_ticks_ff);
            end
         end
      end

      rsp_hold_in  = (rsp_event_in == EV_HOLD) ? hold_ticks_in : '0;
      rsp_valid_in = accept ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_level_ff       <= 1'b1;
         debounce_pending_ff <= 1'b0;
         debounce_elapsed_ff <= '0;
         repeat_elapsed_ff   <= '0;
         gesture_ff          <= GS_START;
         hold_ticks_ff       <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         last_level_ff       <= last_level_in;
         debounce_pending_ff <= debounce_pending_in;
         debounce_elapsed_ff <= debounce_elapsed_in;
         repeat_elapsed_ff   <= repeat_elapsed_in;
         gesture_ff          <= gesture_in;
         hold_ticks_ff       <= hold_ticks_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_event_ff <= rsp_event_in;
         rsp_hold_ff  <= rsp_hold_in;
      end
   end

   // a hold count only travels with a hold event
   `BDGD_ASSERT_IMPLIES(a_hold_count_only_on_hold, rsp_valid_ff && (rsp_hold_ff != '0), rsp_event_ff == EV_HOLD)
   // a changed level restarts debounce and reports nothing
   `BDGD_ASSERT_NEXT(a_change_restarts, accept && (req_pin_level != last_level_ff), debounce_pending_ff && (debounce_elapsed_ff == '0) && (rsp_event_ff == EV_NONE))
   // gesture machine only moves on an accepted item
   `BDGD_ASSERT_NEXT(a_gesture_moves_on_item, !accept, $stable(gesture_ff) && $stable(hold_ticks_ff))
   // hold events only come out of the hold-capable states
   `BDGD_ASSERT_NEXT(a_hold_event_in_hold, accept && (rsp_event_in == EV_HOLD), gesture_ff == GS_HOLD)

endmodule

>>> sim/tb_button_debounce_gesture_detector_unit.sv
// Self-checking testbench for button_debounce_gesture_detector_unit: directed table, then
// random gesture bursts under several register settings, checked against an in-bench predictor.
// Depends on bdgd_pkg and the RTL top level only.
`timescale 1ns / 100ps

module tb_button_debounce_gesture_detector_unit;
   import bdgd_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   localparam int DRAIN_SLACK = 4;
   localparam int DIRECTED_ROWS = 29;
   localparam int IDLE_PCT = 8;
   localparam int RSP_HOLD_OFF_CYCLES = 300;
   localparam int MAX_PRINTED = 30;
   // indexes past the last register; the block must ignore writes to them
   localparam logic [CsrIndexWidth-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_SPARE_B = 2'd3;

   typedef struct packed {
      event_code_type          code;
      logic [CountWidth-1:0]   hold;
   } gesture_result_type;

   typedef struct packed {
      logic                     is_csr;
      logic [CsrIndexWidth-1:0] csr_idx;
      logic [TicksWidth-1:0]    csr_val;
      logic                     level;
      logic                     typed;
      event_code_type           want_code;
      logic [CountWidth-1:0]    want_hold;
   } directed_row_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic                     req_pin_level;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [EventWidth-1:0]    rsp_event_code;
   logic [CountWidth-1:0]    rsp_hold_count;
   logic                     csr_write_en;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [TicksWidth-1:0]    csr_wdata;

   // predictor state and its copy of the registers
   logic                  pin_seen;
   bit                    debounce_armed;
   logic [CountWidth-1:0] debounce_run;
   logic [CountWidth-1:0] repeat_run;
   logic [CountWidth-1:0] hold_run;
   gesture_state_type     gesture_now;
   logic [TicksWidth-1:0] cfg_debounce;
   logic [TicksWidth-1:0] cfg_repeat;

   gesture_result_type pending_results[$];
   int                 items_sent;
   int                 results_seen;
   int                 holds_seen;
   int                 mismatch_count;
   int unsigned        cycle_count;
   bit                 steady_run;
   bit                 hold_off_armed;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{1'b0, 2'd0, 16'd0, 1'b1, 1'b1, EV_NONE, 16'd0},    // released level right after reset
      '{1'b0, 2'd0, 16'd0, 1'b0, 1'b1, EV_NONE, 16'd0},    // changed level never reports
      '{1'b0, 2'd0, 16'd0, 1'b0, 1'b0, EV_NONE, 16'd0},
      '{1'b1, CSR_DEBOUNCE_TICKS, 16'd0, 1'b0, 1'b0, EV_NONE, 16'd0},
      '{1'b1, CSR_REPEAT_TICKS, 16'd0, 1'b0, 1'b0, EV_NONE, 16'd0},
      '{1'b1, CSR_SPARE_A, 16'h1234, 1'b0, 1'b0, EV_NONE, 16'd0},
      '{1'b1, CSR_SPARE_B, 16'hFFFF, 1'b0, 1'b0, EV_NONE, 16'd0},
      '{1'b0, 2'd0, 16'd0, 1'b0, 1'b1, EV_DOWN, 16'd0},    // debounce wins over the tick
      '{1'b0, 2'd0, 16'd0, 1'b0, 1'b0, EV_NONE, 16'd0},
      '{1'b0, 2'd0, 16'd0, 1'b0, 1'b0, EV_NONE, 16'd0},
      '{1'b0, 2'd0, 16'd0, 1'b1, 1'b1, EV_NONE, 16'd0},
      '{1'b0, 2'd0, 16'd0, 1'b1, 1'b1, EV_UP, 16'd0},
      '{1'b1, CSR_REPEAT_TICKS, 16'd2, 1'b0, 1'b0, EV_NONE, 16'd0},
      // double click, then the tick that reports it
      '{1'b0, 2'd0, 16'd0, 1'b0, 1'b0, EV_NONE, 16'd0},
      '{1'b0, 2'd0, 16'd0, 1'b0, 1'b0, EV_NONE, 16'd0},
      '{1'b0, 2'd0, 16'd0, 1'b1, 1'b0, EV_NONE, 16'd0},
      '{1'b0, 2'd0, 16'd0, 1'b1, 1'b0, EV_NONE, 16'd0},
      '{1'b0, 2'd0, 16'd0, 1'b0, 1'b0, EV_NONE, 16'd0},
      '{1'b0, 2'd0, 16'd0, 1'b0, 1'b0, EV_NONE, 16'd0},
      '{1'b0, 2'd0, 16'd0, 1'b1, 1'b0, EV_NONE, 16'd0},
      '{1'b0, 2'd0, 16'd0, 1'b1, 1'b0, EV_NONE, 16'd0},
      '{1'b0, 2'd0, 16'd0, 1'b1, 1'b0, EV_NONE, 16'd0},
      '{1'b0, 2'd0, 16'd0, 1'b1, 1'b0, EV_NONE, 16'd0},
      '{1'b1, CSR_DEBOUNCE_TICKS, 16'hFFFF, 1'b0, 1'b0, EV_NONE, 16'd0},
      '{1'b1, CSR_REPEAT_TICKS, 16'hFFFF, 1'b0, 1'b0, EV_NONE, 16'd0},
      '{1'b0, 2'd0, 16'd0, 1'b0, 1'b1, EV_NONE, 16'd0},
      '{1'b0, 2'd0, 16'd0, 1'b0, 1'b0, EV_NONE, 16'd0},
      '{1'b1, CSR_DEBOUNCE_TICKS, 16'd50, 1'b0, 1'b0, EV_NONE, 16'd0},
      '{1'b1, CSR_REPEAT_TICKS, 16'd200, 1'b0, 1'b0, EV_NONE, 16'd0}
   };

   button_debounce_gesture_detector_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pin_level  (req_pin_level),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_code (rsp_event_code),
      .rsp_hold_count (rsp_hold_count),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still owed", cycle_count,
                  pending_results.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic logic [CountWidth-1:0] bump_count(logic [CountWidth-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   // advances the gesture machine by one debounced edge or tick; returns the tick's event
   function automatic event_code_type feed_gesture(feed_kind_type kind);
      gesture_state_type nxt;
      event_code_type    ev;
      ev = EV_NONE;
      if (kind == FEED_TICK) begin
         if (gesture_now == GS_DOWN1 || gesture_now == GS_HOLD)
            ev = EV_HOLD;
         else if (gesture_now >= GS_CLICK1 && gesture_now <= GS_CLICK5 && !gesture_now[0])
            ev = event_code_type'(4'(EV_CLICK + ((gesture_now - GS_CLICK1) >> 1)));
      end
      case (gesture_now)
         GS_START: nxt = (kind == FEED_DOWN) ? GS_DOWN1 : GS_START;
         GS_HOLD:  nxt = (kind == FEED_UP) ? GS_START : GS_HOLD;
         GS_DOWN1, GS_DOWN2, GS_DOWN3, GS_DOWN4, GS_DOWN5: begin
            if (kind == FEED_DOWN)
               nxt = gesture_now;
            else if (kind == FEED_UP)
               nxt = gesture_state_type'(4'(gesture_now + 1));
            else
               nxt = (gesture_now == GS_DOWN1) ? GS_HOLD : GS_INVALID;
         end
         GS_CLICK1, GS_CLICK2, GS_CLICK3, GS_CLICK4, GS_CLICK5: begin
            if (kind == FEED_DOWN)
               nxt = (gesture_now == GS_CLICK5) ? GS_INVALID
                                                : gesture_state_type'(4'(gesture_now + 1));
            else if (kind == FEED_UP)
               nxt = gesture_now;
            else
               nxt = GS_START;
         end
         default: nxt = (kind == FEED_UP) ? GS_START : GS_INVALID;
      endcase
      if (nxt == GS_HOLD) begin
         if (gesture_now != GS_HOLD)
            hold_run = '0;
         hold_run = bump_count(hold_run);
      end
      gesture_now = nxt;
      return ev;
   endfunction

   function automatic gesture_result_type predict_sample(logic level);
      gesture_result_type    res;
      logic [TicksWidth-1:0] period;
      event_code_type        ev;
      ev = EV_NONE;
      period = (cfg_repeat == '0) ? TicksWidth'(1) : cfg_repeat;
      repeat_run = bump_count(repeat_run);
      if (level != pin_seen) begin
         pin_seen = level;
         debounce_armed = 1'b1;
         debounce_run = '0;
      end else begin
         // a due debounce goes first and restarts the tick period
         if (debounce_armed) begin
            debounce_run = bump_count(debounce_run);
            if (debounce_run >= cfg_debounce) begin
               debounce_armed = 1'b0;
               repeat_run = '0;
               ev = level ? EV_UP : EV_DOWN;
               void'(feed_gesture(level ? FEED_UP : FEED_DOWN));
            end
         end
         if (repeat_run >= period) begin
            repeat_run = '0;
            ev = feed_gesture(FEED_TICK);
         end
      end
      res.code = ev;
      res.hold = (ev == EV_HOLD) ? hold_run : '0;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("[%0t] mismatch on %s: got %0d, expected %0d (result %0d)", $time, what,
                  got, want, results_seen);
   endtask

   task automatic check_result(input logic [EventWidth-1:0] code,
                               input logic [CountWidth-1:0] hold);
      gesture_result_type want;
      if (pending_results.size() == 0) begin
         report_mismatch("result with nothing outstanding", code, -1);
         return;
      end
      want = pending_results.pop_front();
      results_seen++;
      if (code === EV_HOLD)
         holds_seen++;
      if (code !== want.code)
         report_mismatch("event_code", code, want.code);
      if (hold !== want.hold)
         report_mismatch("hold_count", hold, want.hold);
   endtask

   initial begin : result_sink
      int hold_off_left;
      hold_off_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            check_result(rsp_event_code, rsp_hold_count);
         if (hold_off_armed) begin
            hold_off_armed = 1'b0;
            hold_off_left = RSP_HOLD_OFF_CYCLES;
         end
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Called in the step of the previous acceptance, so valid is either kept or dropped once.
   task automatic push_sample(input logic level, input bit typed = 1'b0,
                              input gesture_result_type typed_want = '0);
      gesture_result_type res;
      if (!steady_run && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pin_level <= level;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      res = predict_sample(level);
      pending_results.push_back(typed ? typed_want : res);
      items_sent++;
   endtask

   task automatic send_run(input logic level, input int count);
      repeat (count) push_sample(level);
   endtask

   task automatic send_noise(input int count);
      repeat (count) push_sample(1'($urandom_range(1)));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   task automatic write_register(input logic [CsrIndexWidth-1:0] idx,
                                 input logic [TicksWidth-1:0] value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_DEBOUNCE_TICKS)
         cfg_debounce = value;
      else if (idx == CSR_REPEAT_TICKS)
         cfg_repeat = value;
      @(posedge clock);
   endtask

   // optional contact bounce before settling on a level
   task automatic bounce_into(input logic level, input int deb);
      if ($urandom_range(99) < 30) begin
         repeat ($urandom_range(1, 3)) begin
            send_run(level, $urandom_range(1, deb + 1));
            send_run(~level, 1);
         end
      end
   endtask

   // one to six presses; the last press sometimes turns into a hold
   task automatic play_gesture_burst();
      int clicks;
      int deb;
      int period;
      deb = cfg_debounce;
      period = (cfg_repeat == '0) ? 1 : cfg_repeat;
      clicks = $urandom_range(1, 6);
      for (int c = 0; c < clicks; c++) begin
         bounce_into(1'b0, deb);
         if (c == clicks - 1 && $urandom_range(99) < 25)
            send_run(1'b0, deb + period * $urandom_range(2, 6));
         else
            send_run(1'b0, $urandom_range(deb + 1, deb + period));
         bounce_into(1'b1, deb);
         if (c == clicks - 1)
            send_run(1'b1, deb + 2 * period + 2);
         else
            send_run(1'b1, $urandom_range(deb + 1, deb + period));
      end
   endtask

   task automatic run_random_phase(input logic [TicksWidth-1:0] deb,
                                   input logic [TicksWidth-1:0] rep, input int target,
                                   input bit steady, input bit squeeze);
      int start;
      drain_results();
      write_register(CSR_DEBOUNCE_TICKS, deb);
      write_register(CSR_REPEAT_TICKS, rep);
      steady_run = steady;
      if (squeeze)
         hold_off_armed = 1'b1;
      start = items_sent;
      while (items_sent - start < target) begin
         if ($urandom_range(99) < 15)
            send_noise($urandom_range(4, 20));
         else
            play_gesture_burst();
      end
      steady_run = 1'b0;
   endtask

   initial begin : stimulus
      gesture_result_type typed_want;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_pin_level <= 1'b1;
      csr_write_en <= 1'b0;
      csr_index <= CSR_DEBOUNCE_TICKS;
      csr_wdata <= '0;
      cycle_count = 0;
      items_sent = 0;
      results_seen = 0;
      holds_seen = 0;
      mismatch_count = 0;
      steady_run = 1'b0;
      hold_off_armed = 1'b0;
      pin_seen = 1'b1;
      debounce_armed = 1'b0;
      debounce_run = '0;
      repeat_run = '0;
      hold_run = '0;
      gesture_now = GS_START;
      cfg_debounce = DebounceTicksReset;
      cfg_repeat = RepeatTicksReset;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            drain_results();
            write_register(directed_rows[i].csr_idx, directed_rows[i].csr_val);
         end else begin
            typed_want.code = directed_rows[i].want_code;
            typed_want.hold = directed_rows[i].want_hold;
            push_sample(directed_rows[i].level, directed_rows[i].typed, typed_want);
         end
      end

      run_random_phase(16'd2, 16'd6, 150, 1'b1, 1'b0);
      run_random_phase(16'd0, 16'd1, 150, 1'b0, 1'b1);
      run_random_phase(16'($urandom_range(0, 4)), 16'($urandom_range(2, 12)), 150,
                       1'b0, 1'b0);
      run_random_phase(16'd1, 16'd0, 150, 1'b0, 1'b0);
      run_random_phase(16'($urandom_range(0, 4)), 16'($urandom_range(1, 12)), 150,
                       1'b0, 1'b1);
      run_random_phase(16'd3, 16'd9, 150, 1'b0, 1'b0);
      drain_results();

      $display("%0d pin samples sent (directed table, multi-click/hold bursts with bounce",
               items_sent);
      $display("and noise, long output stalls); %0d results checked, %0d holds, %0d bad",
               results_seen, holds_seen, mismatch_count);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
